/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the lap split recorder RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off while in reset.
`define ASSERT_HOLDS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Implication in the same cycle, off while in reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lsr_pkg.sv */
// Package for the lap split recorder: widths, codes and request/result types.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lsr_pkg;

    localparam int LAPS           = 4;
    localparam int CENTIS_PER_SEC = 100;

    localparam int OP_W           = 2;
    localparam int SEC_W          = 16;
    localparam int CSEC_W         = 7;
    localparam int SLOT_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int TOTAL_W        = 23;
    localparam int LAPS_DONE_W    = 3;
    localparam int IDX_W          = (LAPS > 1) ? $clog2(LAPS) : 1;
    localparam int CNT_W          = $clog2(LAPS + 1);

    typedef enum logic [OP_W-1:0] {
        OP_LAP      = 2'd0,
        OP_CLEAR    = 2'd1,
        OP_READ     = 2'd2,
        OP_READ_ALT = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RECORDED = 2'd0,
        ST_FULL     = 2'd1,
        ST_CLEARED  = 2'd2,
        ST_READ     = 2'd3
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SEC_W-1:0]  abs_sec;
        logic [CSEC_W-1:0] abs_centis;
        logic [SLOT_W-1:0] slot_index;
    } lsr_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [SLOT_W-1:0]      lap_slot;
        logic [SEC_W-1:0]       split_seconds;
        logic [CSEC_W-1:0]      split_centis;
        logic                   lap_present;
        logic [TOTAL_W-1:0]     best_split;
        logic [LAPS_DONE_W-1:0] laps_done;
        logic                   stop_pulse;
    } lsr_out_t;

    // Request after the front stage: folded centiseconds and total time.
    typedef struct packed {
        op_t                op;
        logic [SEC_W-1:0]   sec;
        logic [CSEC_W-1:0]  csec;
        logic [TOTAL_W-1:0] time_total;
        logic [SLOT_W-1:0]  slot;
    } lsr_stage_t;

endpackage

`default_nettype wire

/* hw/rtl/lsr_front.sv */
// Front stage: folds centiseconds, forms total centiseconds, registers the request.
// Depends on lsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsr_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire lsr_pkg::lsr_in_t   s_data,
    input  wire logic               advance,
    output logic                    stage_valid,
    output lsr_pkg::lsr_stage_t     stage_data
);
    import lsr_pkg::*;

    logic               stage_valid_reg;
    logic               stage_valid_next;
    lsr_stage_t         stage_data_reg;
    lsr_stage_t         stage_data_next;
    logic [CSEC_W-1:0]  csec_fold;
    logic               take;

    assign s_ready = !stage_valid_reg || advance;
    assign take    = s_valid && s_ready;

    always_comb begin
        if (s_data.abs_centis >= CSEC_W'(CENTIS_PER_SEC)) begin
            csec_fold = s_data.abs_centis - CSEC_W'(CENTIS_PER_SEC);
        end else begin
            csec_fold = s_data.abs_centis;
        end
        stage_data_next.op         = op_t'(s_data.op);
        stage_data_next.sec        = s_data.abs_sec;
        stage_data_next.csec       = csec_fold;
        stage_data_next.time_total = TOTAL_W'(s_data.abs_sec) * TOTAL_W'(CENTIS_PER_SEC)
                                   + TOTAL_W'(csec_fold);
        stage_data_next.slot       = s_data.slot_index;

        if (take) begin
            stage_valid_next = 1'b1;
        end else if (advance) begin
            stage_valid_next = 1'b0;
        end else begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            stage_data_reg <= stage_data_next;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage_data  = stage_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/lsr_core.sv */
// Core stage: lap records, split arithmetic, best split and the result register.
// Depends on lsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsr_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                stage_valid,
    input  wire lsr_pkg::lsr_stage_t stage_data,
    output logic                     advance,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lsr_pkg::lsr_out_t        m_data
);
    import lsr_pkg::*;

    logic [CNT_W-1:0]   lap_total_reg,  lap_total_next;
    logic [TOTAL_W-1:0] last_total_reg, last_total_next;
    logic [SEC_W-1:0]   last_sec_reg,   last_sec_next;
    logic [CSEC_W-1:0]  last_csec_reg,  last_csec_next;
    logic [TOTAL_W-1:0] best_total_reg, best_total_next;
    logic [SEC_W-1:0]   sec_store_reg  [LAPS];
    logic [SEC_W-1:0]   sec_store_next [LAPS];
    logic [CSEC_W-1:0]  csec_store_reg [LAPS];
    logic [CSEC_W-1:0]  csec_store_next[LAPS];
    logic               m_valid_reg, m_valid_next;
    lsr_out_t           m_data_reg, res;

    logic               full;
    logic               behind;
    logic [TOTAL_W-1:0] lap_span;
    logic [CSEC_W:0]    csec_diff;
    logic               borrow;
    logic [SEC_W-1:0]   span_sec;
    logic [CSEC_W-1:0]  span_csec;
    logic [IDX_W-1:0]   wr_idx;
    logic [IDX_W-1:0]   rd_idx;
    logic [CNT_W-1:0]   lap_total_inc;

    assign advance = stage_valid && (!m_valid_reg || m_ready);

    always_comb begin
        full          = (lap_total_reg == CNT_W'(LAPS));
        behind        = (stage_data.time_total < last_total_reg);
        lap_total_inc = lap_total_reg + CNT_W'(1);
        wr_idx        = lap_total_reg[IDX_W-1:0];
        rd_idx        = stage_data.slot[IDX_W-1:0];

        // split as a sec/csec pair, borrowing a second when centiseconds wrap
        csec_diff = {1'b0, stage_data.csec} - {1'b0, last_csec_reg};
        borrow    = csec_diff[CSEC_W];
        if (behind) begin
            lap_span  = '0;
            span_sec  = '0;
            span_csec = '0;
        end else begin
            lap_span  = stage_data.time_total - last_total_reg;
            span_sec  = stage_data.sec - last_sec_reg - SEC_W'(borrow);
            span_csec = borrow ? csec_diff[CSEC_W-1:0] + CSEC_W'(CENTIS_PER_SEC)
                               : csec_diff[CSEC_W-1:0];
        end

        lap_total_next  = lap_total_reg;
        last_total_next = last_total_reg;
        last_sec_next   = last_sec_reg;
        last_csec_next  = last_csec_reg;
        best_total_next = best_total_reg;
        sec_store_next  = sec_store_reg;
        csec_store_next = csec_store_reg;

        res             = '0;
        res.best_split  = best_total_reg;
        res.laps_done   = LAPS_DONE_W'(lap_total_reg);

        case (stage_data.op)
            OP_LAP: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    sec_store_next[wr_idx]  = span_sec;
                    csec_store_next[wr_idx] = span_csec;
                    if (best_total_reg == '0 || lap_span < best_total_reg) begin
                        best_total_next = lap_span;
                    end
                    lap_total_next    = lap_total_inc;
                    last_total_next   = stage_data.time_total;
                    last_sec_next     = stage_data.sec;
                    last_csec_next    = stage_data.csec;
                    res.status        = ST_RECORDED;
                    res.lap_slot      = SLOT_W'(wr_idx);
                    res.split_seconds = span_sec;
                    res.split_centis  = span_csec;
                    res.lap_present   = 1'b1;
                    res.best_split    = best_total_next;
                    res.laps_done     = LAPS_DONE_W'(lap_total_inc);
                    res.stop_pulse    = (lap_total_inc == CNT_W'(LAPS));
                end
            end
            OP_CLEAR: begin
                lap_total_next  = '0;
                last_total_next = '0;
                last_sec_next   = '0;
                last_csec_next  = '0;
                best_total_next = '0;
                for (int i = 0; i < LAPS; i++) begin
                    sec_store_next[i]  = '0;
                    csec_store_next[i] = '0;
                end
                res        = '0;
                res.status = ST_CLEARED;
            end
            default: begin
                res.status   = ST_READ;
                res.lap_slot = stage_data.slot;
                if (32'(stage_data.slot) < LAPS) begin
                    res.split_seconds = sec_store_reg[rd_idx];
                    res.split_centis  = csec_store_reg[rd_idx];
                    res.lap_present   = (CNT_W'(stage_data.slot) < lap_total_reg);
                end
            end
        endcase

        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lap_total_reg  <= '0;
            last_total_reg <= '0;
            last_sec_reg   <= '0;
            last_csec_reg  <= '0;
            best_total_reg <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < LAPS; i++) begin
                sec_store_reg[i]  <= '0;
                csec_store_reg[i] <= '0;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                lap_total_reg  <= lap_total_next;
                last_total_reg <= last_total_next;
                last_sec_reg   <= last_sec_next;
                last_csec_reg  <= last_csec_next;
                best_total_reg <= best_total_next;
                sec_store_reg  <= sec_store_next;
                csec_store_reg <= csec_store_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/lap_split_recorder_top.sv */
// Lap split recorder: a request is taken into the front register, and its result is
// loaded into the result register when that register is empty or m_ready is high.
// Throughput is one request per cycle while m_ready stays high, set by the front and result registers.
// Synchronous active-low reset clears all lap records, the best split and both
// valid flags; the block takes requests as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lap_split_recorder_top (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire lsr_pkg::lsr_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lsr_pkg::lsr_out_t      m_data
);
    import lsr_pkg::*;

    logic       advance;
    logic       stage_valid;
    lsr_stage_t stage_data;

    lsr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_data  (stage_data)
    );

    lsr_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stage_valid (stage_valid),
        .stage_data  (stage_data),
        .advance     (advance),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    `ASSERT_IMPLIES(a_stop_on_last, aclk, aresetn, m_valid && m_data.stop_pulse, m_data.status == ST_RECORDED && m_data.laps_done == LAPS_DONE_W'(LAPS), "stop pulse without final lap")
    `ASSERT_IMPLIES(a_clear_zero, aclk, aresetn, m_valid && m_data.status == ST_CLEARED, m_data.best_split == '0 && m_data.laps_done == '0, "clear left records")
    `ASSERT_IMPLIES(a_full_count, aclk, aresetn, m_valid && m_data.status == ST_FULL, m_data.laps_done == LAPS_DONE_W'(LAPS), "full reported before last slot")
    `ASSERT_IMPLIES(a_lap_slot, aclk, aresetn, m_valid && m_data.status == ST_RECORDED, m_data.lap_present && m_data.lap_slot == SLOT_W'(m_data.laps_done - 3'd1), "recorded lap in wrong slot")
    `ASSERT_HOLDS(a_no_stall_loss, aclk, aresetn, !(stage_valid && m_valid && !m_ready && advance), "request advanced into stalled result")

endmodule

`default_nettype wire
